### sv/toy_card_machine_cpu_unit_macros.svh
// assertion macros for the toy card machine cpu unit
// used by the top level; no other dependencies
`ifndef TOY_CARD_MACHINE_CPU_UNIT_MACROS_SVH
`define TOY_CARD_MACHINE_CPU_UNIT_MACROS_SVH
`ifndef SYNTH
`define TCM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcm assertion failed");
`define TCM_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tcm forbidden condition seen");
`else
`define TCM_ASSERT(lbl, clk, rst_n, prop)
`define TCM_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### sv/tcm_pkg.sv
// shared types, codes and helpers of the toy card machine cpu unit
// no dependencies
package tcm_pkg;
  localparam int ADDR_W = 7;
  localparam logic [31:0] SPACES = 32'h2020_2020;
  localparam logic [13:0] SAT14 = 14'h3FFF;
  localparam logic [6:0] CUR_MAX = 7'd127;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  typedef enum logic [2:0] {
    K_DONE    = 3'd0,
    K_AWAIT   = 3'd1,
    K_PRINT   = 3'd2,
    K_HALT    = 3'd3,
    K_TIME    = 3'd4,
    K_BADADDR = 3'd5,
    K_REJECT  = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PROG  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CARD  = 2'd3
  } op_t;

  typedef enum logic {
    REG_TIME_LIMIT = 1'b0,
    REG_LINE_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_FETCH, S_DEC, S_OPER, S_MERGE, S_PRINT
  } state_t;

  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [13:0] time_limit;
    logic [13:0] line_limit;
  } cfg_t;

  function automatic logic [31:0] char_mask(input logic [2:0] vb);
    logic [31:0] m;
    case (vb)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction
endpackage

### sv/tcm_ifs.sv
// channel interfaces of the toy card machine cpu unit
// no dependencies
interface tcm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  modport source(output valid, op, data_word, valid_bytes, input ready);
  modport sink(input valid, op, data_word, valid_bytes, output ready);
endinterface

interface tcm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] print_word;
  logic        last;
  logic        line_over;
  logic [6:0]  counter;
  modport source(output valid, kind, print_word, last, line_over, counter, input ready);
  modport sink(input valid, kind, print_word, last, line_over, counter, output ready);
endinterface

interface tcm_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [13:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/tcm_store.sv
// main store: one write port, one registered read port, per-word valid bits
// depends on tcm_pkg
module tcm_store
  import tcm_pkg::*;
#(
  parameter int MEM_WORDS = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mem_req_t    req,
  output logic [31:0] rd_data
);
  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0]          mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_r;
  logic [31:0]          rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= vld_r[req.rd_addr[AW-1:0]] ? mem[req.rd_addr[AW-1:0]] : SPACES;
    end
  end

  assign rd_data = rd_data_r;
endmodule

### sv/tcm_seq.sv
// sequencer: decodes words, runs instructions against the store, drives results
// depends on tcm_pkg and tcm_ifs
module tcm_seq
  import tcm_pkg::*;
#(
  parameter int MEM_WORDS  = 100,
  parameter int CARD_WORDS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  tcm_in_if.sink       in_ch,
  tcm_out_if.source    out_ch,
  output mem_req_t     mem_req,
  input  logic [31:0]  mem_rd
);
  localparam logic [6:0] MEMW = 7'(MEM_WORDS);
  localparam logic [7:0] MEMW8 = 8'(MEM_WORDS);
  localparam logic [3:0] CW4 = 4'(CARD_WORDS);

  state_t      state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic [31:0] word_r, word_nxt;
  logic [2:0]  vb_r, vb_nxt;
  logic [31:0] instr_r, instr_nxt;
  logic [31:0] gen_r, gen_nxt;
  logic [6:0]  ic_r, ic_nxt;
  logic        flag_r, flag_nxt;
  logic [13:0] steps_r, steps_nxt;
  logic [13:0] lines_r, lines_nxt;
  logic [6:0]  lcur_r, lcur_nxt;
  logic [6:0]  ccur_r, ccur_nxt;
  logic [3:0]  cleft_r, cleft_nxt;
  logic        cend_r, cend_nxt;
  logic        halt_r, halt_nxt;
  logic [6:0]  loc_r, loc_nxt;
  logic [6:0]  tgt_r, tgt_nxt;
  logic [3:0]  pidx_r, pidx_nxt;
  logic        poob_r, poob_nxt;
  logic        over_r, over_nxt;

  logic        ov_r;
  kind_t       okind_r;
  logic [31:0] oword_r;
  logic        olast_r, oover_r;
  logic [6:0]  octr_r;

  logic        emit, elast, eover, do_card;
  kind_t       ekind;
  logic [31:0] eword;
  logic [7:0]  c0, c1, d2, d3;
  logic        ok_op, loc_bad;
  logic [6:0]  loc;
  logic [13:0] steps_inc, lines_inc;
  logic [31:0] merged;
  logic [7:0]  pa;

  assign c0 = instr_r[31:24];
  assign c1 = instr_r[23:16];
  assign d2 = instr_r[15:8];
  assign d3 = instr_r[7:0];
  assign ok_op = (c0 == CH_L && c1 == CH_R) || (c0 == CH_S && c1 == CH_R) ||
                 (c0 == CH_C && c1 == CH_R) || (c0 == CH_B && c1 == CH_T) ||
                 (c0 == CH_G && c1 == CH_D) || (c0 == CH_P && c1 == CH_D);
  assign loc = {3'b000, d2[3:0]} * 7'd10 + {3'b000, d3[3:0]};
  assign loc_bad = !is_digit(d2) || !is_digit(d3) || (loc >= MEMW);
  assign steps_inc = (steps_r == SAT14) ? steps_r : steps_r + 14'd1;
  assign lines_inc = (lines_r == SAT14) ? lines_r : lines_r + 14'd1;
  assign merged = (mem_rd & ~char_mask(vb_r)) | (word_r & char_mask(vb_r));
  assign pa = 8'(loc_r) + 8'(pidx_r) + 8'd1;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    word_nxt  = word_r;
    vb_nxt    = vb_r;
    instr_nxt = instr_r;
    gen_nxt   = gen_r;
    ic_nxt    = ic_r;
    flag_nxt  = flag_r;
    steps_nxt = steps_r;
    lines_nxt = lines_r;
    lcur_nxt  = lcur_r;
    ccur_nxt  = ccur_r;
    cleft_nxt = cleft_r;
    cend_nxt  = cend_r;
    halt_nxt  = halt_r;
    loc_nxt   = loc_r;
    tgt_nxt   = tgt_r;
    pidx_nxt  = pidx_r;
    poob_nxt  = poob_r;
    over_nxt  = over_r;
    mem_req   = '0;
    emit      = 1'b0;
    ekind     = K_DONE;
    eword     = '0;
    elast     = 1'b1;
    eover     = 1'b0;
    do_card   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = op_t'(in_ch.op);
          word_nxt  = in_ch.data_word;
          vb_nxt    = (in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (!ov_r) begin
          state_nxt = S_IDLE;
          emit      = 1'b1;
          unique case (op_r)
            OP_START: begin
              mem_req.clr = 1'b1;
              instr_nxt   = SPACES;
              gen_nxt     = SPACES;
              ic_nxt      = '0;
              flag_nxt    = 1'b0;
              steps_nxt   = '0;
              lines_nxt   = '0;
              lcur_nxt    = '0;
              ccur_nxt    = '0;
              cleft_nxt   = '0;
              cend_nxt    = 1'b0;
              halt_nxt    = 1'b0;
            end
            OP_PROG: begin
              if (lcur_r >= MEMW) begin
                ekind = K_REJECT;
              end else if (vb_r != 3'd0) begin
                emit            = 1'b0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = lcur_r;
                tgt_nxt         = lcur_r;
                state_nxt       = S_MERGE;
              end
            end
            OP_STEP: begin
              if (halt_r || cleft_r != 4'd0) begin
                ekind = K_REJECT;
              end else begin
                steps_nxt = steps_inc;
                if (steps_inc > cfg.time_limit) begin
                  halt_nxt = 1'b1;
                  ekind    = K_TIME;
                end else if (ic_r >= MEMW) begin
                  halt_nxt = 1'b1;
                  ekind    = K_BADADDR;
                end else begin
                  emit            = 1'b0;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = ic_r;
                  state_nxt       = S_FETCH;
                end
              end
            end
            OP_CARD: begin
              if (cleft_r == 4'd0) begin
                ekind = K_REJECT;
              end else if (!cend_r && ccur_r < MEMW) begin
                emit            = 1'b0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ccur_r;
                tgt_nxt         = ccur_r;
                state_nxt       = S_MERGE;
              end else begin
                emit    = 1'b0;
                do_card = 1'b1;
              end
            end
            default: ekind = K_REJECT;
          endcase
        end
      end
      S_FETCH: begin
        instr_nxt = mem_rd;
        ic_nxt    = ic_r + 7'd1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_IDLE;
        emit      = 1'b1;
        if (c0 == CH_H) begin
          halt_nxt = 1'b1;
          ekind    = K_HALT;
        end else if (!ok_op) begin
          ekind = K_DONE;
        end else if (loc_bad) begin
          halt_nxt = 1'b1;
          ekind    = K_BADADDR;
        end else begin
          unique case (c0)
            CH_L, CH_C: begin
              emit            = 1'b0;
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = loc;
              state_nxt       = S_OPER;
            end
            CH_S: begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = loc;
              mem_req.wr_data = gen_r;
            end
            CH_B: begin
              if (flag_r) ic_nxt = loc;
            end
            CH_G: begin
              ccur_nxt  = loc;
              cleft_nxt = CW4;
              cend_nxt  = 1'b0;
              ekind     = K_AWAIT;
            end
            CH_P: begin
              emit            = 1'b0;
              lines_nxt       = lines_inc;
              over_nxt        = lines_inc > cfg.line_limit;
              loc_nxt         = loc;
              pidx_nxt        = '0;
              poob_nxt        = 1'b0;
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = loc;
              state_nxt       = S_PRINT;
            end
            default: ekind = K_DONE;
          endcase
        end
      end
      S_OPER: begin
        if (c0 == CH_L) gen_nxt = mem_rd;
        else flag_nxt = (gen_r == mem_rd);
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_MERGE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = tgt_r;
        mem_req.wr_data = merged;
        if (op_r == OP_PROG) begin
          lcur_nxt  = lcur_r + 7'd1;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          do_card = 1'b1;
        end
      end
      S_PRINT: begin
        if (!ov_r || out_ch.ready) begin
          emit  = 1'b1;
          ekind = K_PRINT;
          eword = poob_r ? SPACES : mem_rd;
          elast = (pidx_r == CW4 - 4'd1);
          eover = over_r;
          if (elast) begin
            state_nxt = S_IDLE;
          end else begin
            pidx_nxt        = pidx_r + 4'd1;
            poob_nxt        = pa >= MEMW8;
            mem_req.rd_en   = pa < MEMW8;
            mem_req.rd_addr = pa[6:0];
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_card) begin
      if (!cend_r && vb_r < 3'd4) cend_nxt = 1'b1;
      if (ccur_r < CUR_MAX) ccur_nxt = ccur_r + 7'd1;
      cleft_nxt = cleft_r - 4'd1;
      emit      = 1'b1;
      ekind     = (cleft_r != 4'd1) ? K_AWAIT : K_DONE;
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_START;
      instr_r <= SPACES;
      gen_r   <= SPACES;
      ic_r    <= '0;
      flag_r  <= 1'b0;
      steps_r <= '0;
      lines_r <= '0;
      lcur_r  <= '0;
      ccur_r  <= '0;
      cleft_r <= '0;
      cend_r  <= 1'b0;
      halt_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      instr_r <= instr_nxt;
      gen_r   <= gen_nxt;
      ic_r    <= ic_nxt;
      flag_r  <= flag_nxt;
      steps_r <= steps_nxt;
      lines_r <= lines_nxt;
      lcur_r  <= lcur_nxt;
      ccur_r  <= ccur_nxt;
      cleft_r <= cleft_nxt;
      cend_r  <= cend_nxt;
      halt_r  <= halt_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    vb_r   <= vb_nxt;
    loc_r  <= loc_nxt;
    tgt_r  <= tgt_nxt;
    pidx_r <= pidx_nxt;
    poob_r <= poob_nxt;
    over_r <= over_nxt;
    if (emit) begin
      okind_r <= ekind;
      oword_r <= eword;
      olast_r <= elast;
      oover_r <= eover;
      octr_r  <= ic_nxt;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.kind       = okind_r;
  assign out_ch.print_word = oword_r;
  assign out_ch.last       = olast_r;
  assign out_ch.line_over  = oover_r;
  assign out_ch.counter    = octr_r;
endmodule

### sv/toy_card_machine_cpu_unit.sv
// top level of the toy card machine cpu unit: config registers, sequencer, store
// depends on tcm_pkg, tcm_ifs, tcm_seq, tcm_store and the macros header
//
//   channel  dir  word                                      handshake
//   in_ch    in   op, data_word, valid_bytes                valid/ready
//   out_ch   out  kind, print_word, last, line_over, counter valid/ready
//   cfg_ch   in   index, data                               valid/ready, always ready
//
// one word in flight; a program or card word may read the store, then merge into it,
// a step does a fetch read, then at most one operand read; a print streams one
// word per cycle from the store's read port after the fetch while the output is taken
// a word waits in dispatch until the output register has been taken
// reset and start job clear all of the store's valid bits together, no clearing pass
`include "toy_card_machine_cpu_unit_macros.svh"
module toy_card_machine_cpu_unit
  import tcm_pkg::*;
#(
  parameter int MEM_WORDS  = 100,
  parameter int CARD_WORDS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  tcm_in_if.sink    in_ch,
  tcm_out_if.source out_ch,
  tcm_cfg_if.sink   cfg_ch
);
  cfg_t        cfg_r;
  mem_req_t    mem_req;
  logic [31:0] mem_rd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_TIME_LIMIT: cfg_r.time_limit <= cfg_ch.data;
        REG_LINE_LIMIT: cfg_r.line_limit <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  tcm_seq #(
    .MEM_WORDS (MEM_WORDS),
    .CARD_WORDS(CARD_WORDS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .mem_req(mem_req),
    .mem_rd (mem_rd)
  );

  tcm_store #(
    .MEM_WORDS(MEM_WORDS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mem_req),
    .rd_data(mem_rd)
  );

  `TCM_ASSERT(a_busy_after_accept, clk, rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
  `TCM_NEVER(a_word_only_print, clk, rst_n, out_ch.valid && out_ch.kind != K_PRINT && out_ch.print_word != 32'd0)
  `TCM_NEVER(a_over_only_print, clk, rst_n, out_ch.valid && out_ch.kind != K_PRINT && out_ch.line_over)
  `TCM_NEVER(a_single_is_last, clk, rst_n, out_ch.valid && out_ch.kind != K_PRINT && !out_ch.last)
endmodule
